@@ src/deferred_release_cache_aging_defines.svh @@
// assertion macros for the deferred release cache
`ifndef DEFERRED_RELEASE_CACHE_AGING_DEFINES_SVH
`define DEFERRED_RELEASE_CACHE_AGING_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define DRCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen
`define DRCA_ASSERT_NEVER(label, expr, msg) \
  `DRCA_ASSERT(label, !(expr), msg)

`endif

@@ src/drca_pkg.sv @@
// types, constants and codes shared by the deferred release cache
package drca_pkg;

  localparam int EntriesPerKind = 16;
  localparam int MaxResults     = 32;
  localparam int FillW          = $clog2(EntriesPerKind + 1);
  localparam int IdxW           = (EntriesPerKind > 1) ? $clog2(EntriesPerKind) : 1;
  localparam int AddrW          = IdxW + 1;
  localparam int MemDepth       = 2 * (1 << IdxW);
  localparam int CntW           = $clog2(MaxResults + 1);
  localparam int HashW          = 64;
  localparam int HandleW        = 32;
  localparam int AgeW           = 2;
  localparam logic [AgeW-1:0] AgeMax = 2'd3;
  localparam logic [1:0] KeepReset   = 2'd2;

  typedef enum logic [1:0] {
    CMD_QUEUE  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIN,
    S_LK_RD,
    S_LK_CMP,
    S_SH_RD,
    S_SH_WR,
    S_TK_START,
    S_AG_RD,
    S_AG_EV,
    S_CP_RD,
    S_CP_WR,
    S_TK_END
  } state_e;

  typedef struct packed {
    logic [HashW-1:0]   hash;
    logic [HandleW-1:0] handle;
    logic [AgeW-1:0]    age;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic            match;
    logic [AgeW-1:0] age_next;
    logic            expired;
  } unit_res_t;

  typedef struct packed {
    status_e            status;
    logic               kind;
    logic [HandleW-1:0] handle;
    logic               last;
  } res_t;

endpackage

@@ src/drca_mem.sv @@
// entry storage for both tables, one write and one registered read port
module drca_mem (
  input  logic              clk_i,
  input  drca_pkg::mem_req_t req_i,
  output drca_pkg::entry_t  rdata_o
);
  import drca_pkg::*;

  entry_t mem_q [MemDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/drca_unit.sv @@
// shared compare and age unit applied to one entry per step
module drca_unit (
  input  drca_pkg::entry_t                entry_i,
  input  logic [drca_pkg::HashW-1:0]      key_i,
  input  logic [1:0]                      keep_i,
  output drca_pkg::unit_res_t             res_o
);
  import drca_pkg::*;

  logic [AgeW-1:0] age_next;

  always_comb begin
    age_next = (entry_i.age == AgeMax) ? entry_i.age : entry_i.age + AgeW'(1);
    res_o.match    = (entry_i.hash == key_i);
    res_o.age_next = age_next;
    res_o.expired  = (age_next >= keep_i);
  end

endmodule

@@ src/drca_ctrl.sv @@
// command sequencer: queue, lookup with shift, tick with aging and compaction
`include "deferred_release_cache_aging_defines.svh"

module drca_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_cmd_i,
  input  logic                          in_kind_i,
  input  logic [drca_pkg::HandleW-1:0]  in_handle_i,
  input  logic [drca_pkg::HashW-1:0]    in_hash_i,
  input  logic [1:0]                    keep_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output drca_pkg::res_t                out_res_o,
  output drca_pkg::mem_req_t            mem_req_o,
  input  drca_pkg::entry_t              mem_rdata_i
);
  import drca_pkg::*;

  state_e state_q, state_d;
  logic kind_q, kind_d;
  logic [HashW-1:0] hash_q, hash_d;
  status_e res_status_q, res_status_d;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  logic [FillW-1:0] ptr_q, ptr_d;
  logic [FillW-1:0] wptr_q, wptr_d;
  logic [FillW-1:0] fill_q [2];
  logic [FillW-1:0] fill_d [2];
  logic [EntriesPerKind-1:0] evf_q, evf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic pend_v_q, pend_v_d;
  logic pend_kind_q, pend_kind_d;
  logic [HandleW-1:0] pend_handle_q, pend_handle_d;
  logic out_v_q;
  res_t out_q;

  logic slot_free;
  logic emit;
  res_t emit_res;
  logic ev;
  unit_res_t ures;
  entry_t aged_entry;

  drca_unit u_unit (
    .entry_i (mem_rdata_i),
    .key_i   (hash_q),
    .keep_i  (keep_i),
    .res_o   (ures)
  );

  assign slot_free = !out_v_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    hash_d        = hash_q;
    res_status_d  = res_status_q;
    res_handle_d  = res_handle_q;
    ptr_d         = ptr_q;
    wptr_d        = wptr_q;
    fill_d        = fill_q;
    evf_d         = evf_q;
    cnt_d         = cnt_q;
    pend_v_d      = pend_v_q;
    pend_kind_d   = pend_kind_q;
    pend_handle_d = pend_handle_q;
    mem_req_o     = '0;
    emit          = 1'b0;
    emit_res      = '{status: ST_DONE, kind: 1'b0, handle: '0, last: 1'b0};
    in_ready_o    = 1'b0;
    ev            = 1'b0;
    aged_entry    = mem_rdata_i;
    aged_entry.age = ures.age_next;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d       = in_kind_i;
          hash_d       = in_hash_i;
          res_status_d = ST_DONE;
          res_handle_d = '0;
          case (cmd_e'(in_cmd_i))
            CMD_QUEUE: begin
              if (fill_q[in_kind_i] >= FillW'(EntriesPerKind)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = {in_kind_i, fill_q[in_kind_i][IdxW-1:0]};
                mem_req_o.wdata = '{hash: in_hash_i, handle: in_handle_i, age: '0};
                fill_d[in_kind_i] = fill_q[in_kind_i] + FillW'(1);
              end
              state_d = S_FIN;
            end
            CMD_LOOKUP: begin
              if (fill_q[in_kind_i] == '0) begin
                state_d = S_FIN;
              end else begin
                ptr_d   = fill_q[in_kind_i] - FillW'(1);
                state_d = S_LK_RD;
              end
            end
            CMD_TICK: begin
              kind_d   = 1'b0;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              state_d  = S_TK_START;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_FIN: begin
        if (slot_free) begin
          emit     = 1'b1;
          emit_res = '{status: res_status_q, kind: kind_q, handle: res_handle_q, last: 1'b1};
          state_d  = S_IDLE;
        end
      end

      S_LK_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {kind_q, ptr_q[IdxW-1:0]};
        state_d         = S_LK_CMP;
      end

      S_LK_CMP: begin
        if (ures.match) begin
          res_status_d = ST_HIT;
          res_handle_d = mem_rdata_i.handle;
          if ((ptr_q + FillW'(1)) < fill_q[kind_q]) begin
            state_d = S_SH_RD;
          end else begin
            fill_d[kind_q] = fill_q[kind_q] - FillW'(1);
            state_d        = S_FIN;
          end
        end else if (ptr_q == '0) begin
          state_d = S_FIN;
        end else begin
          ptr_d   = ptr_q - FillW'(1);
          state_d = S_LK_RD;
        end
      end

      S_SH_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {kind_q, ptr_q[IdxW-1:0] + IdxW'(1)};
        state_d         = S_SH_WR;
      end

      S_SH_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {kind_q, ptr_q[IdxW-1:0]};
        mem_req_o.wdata = mem_rdata_i;
        ptr_d           = ptr_q + FillW'(1);
        if ((ptr_q + FillW'(2)) < fill_q[kind_q]) begin
          state_d = S_SH_RD;
        end else begin
          fill_d[kind_q] = fill_q[kind_q] - FillW'(1);
          state_d        = S_FIN;
        end
      end

      S_TK_START: begin
        evf_d = '0;
        if (fill_q[kind_q] == '0) begin
          if (!kind_q) begin
            kind_d = 1'b1;
          end else begin
            state_d = S_TK_END;
          end
        end else begin
          ptr_d   = fill_q[kind_q] - FillW'(1);
          state_d = S_AG_RD;
        end
      end

      S_AG_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {kind_q, ptr_q[IdxW-1:0]};
        state_d         = S_AG_EV;
      end

      S_AG_EV: begin
        ev = ures.expired && (cnt_q < CntW'(MaxResults));
        // a new eviction pushes the held one out, so wait for the output slot
        if (!(ev && pend_v_q && !slot_free)) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = {kind_q, ptr_q[IdxW-1:0]};
          mem_req_o.wdata = aged_entry;
          evf_d[ptr_q[IdxW-1:0]] = ev;
          if (ev) begin
            cnt_d         = cnt_q + CntW'(1);
            pend_v_d      = 1'b1;
            pend_kind_d   = kind_q;
            pend_handle_d = mem_rdata_i.handle;
            if (pend_v_q) begin
              emit     = 1'b1;
              emit_res = '{status: ST_HIT, kind: pend_kind_q, handle: pend_handle_q,
                           last: 1'b0};
            end
          end
          if (ptr_q == '0) begin
            wptr_d  = '0;
            state_d = S_CP_RD;
          end else begin
            ptr_d   = ptr_q - FillW'(1);
            state_d = S_AG_RD;
          end
        end
      end

      S_CP_RD: begin
        if (ptr_q == fill_q[kind_q]) begin
          fill_d[kind_q] = wptr_q;
          if (!kind_q) begin
            kind_d  = 1'b1;
            state_d = S_TK_START;
          end else begin
            state_d = S_TK_END;
          end
        end else if (evf_q[ptr_q[IdxW-1:0]]) begin
          ptr_d = ptr_q + FillW'(1);
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = {kind_q, ptr_q[IdxW-1:0]};
          state_d         = S_CP_WR;
        end
      end

      S_CP_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {kind_q, wptr_q[IdxW-1:0]};
        mem_req_o.wdata = mem_rdata_i;
        wptr_d          = wptr_q + FillW'(1);
        ptr_d           = ptr_q + FillW'(1);
        state_d         = S_CP_RD;
      end

      S_TK_END: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pend_v_q) begin
            emit_res = '{status: ST_HIT, kind: pend_kind_q, handle: pend_handle_q,
                         last: 1'b1};
          end else begin
            emit_res = '{status: ST_DONE, kind: 1'b0, handle: '0, last: 1'b1};
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q[0] <= '0;
      fill_q[1] <= '0;
      evf_q     <= '0;
      cnt_q     <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      evf_q    <= evf_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    hash_q        <= hash_d;
    res_status_q  <= res_status_d;
    res_handle_q  <= res_handle_d;
    ptr_q         <= ptr_d;
    wptr_q        <= wptr_d;
    pend_kind_q   <= pend_kind_d;
    pend_handle_q <= pend_handle_d;
    if (emit) begin
      out_q <= emit_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  `DRCA_ASSERT_NEVER(a_fill0_bound, fill_q[0] > FillW'(EntriesPerKind), "image fill too big")
  `DRCA_ASSERT_NEVER(a_fill1_bound, fill_q[1] > FillW'(EntriesPerKind), "buffer fill too big")
  `DRCA_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(MaxResults), "eviction count above cap")
  `DRCA_ASSERT_NEVER(a_compact_order, (state_q == S_CP_RD) && (wptr_q > ptr_q), "compact overrun")
  `DRCA_ASSERT_NEVER(a_idle_no_pend, (state_q == S_IDLE) && pend_v_q, "held eviction left")
  `DRCA_ASSERT(a_cmp_after_rd, (state_q == S_LK_CMP) |-> $past(state_q == S_LK_RD), "no read")

endmodule

@@ src/deferred_release_cache_aging.sv @@
// top level of the deferred release cache with frame aging
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  cmd, kind, handle_in, key_hash
//  m_axis    out  m_axis_tvalid / m_axis_tready  status, kind_out, handle_out, last
//  cfg       in   cfg_we_i                       frames_to_keep
//
//  queue and unknown commands go straight to the result; a lookup reads and
//  compares entries newest first, then shifts later entries down after a hit
//  a tick per table reads and ages each entry, then for compaction skips each
//  evicted entry and copies each kept one; no step makes two memory accesses
//  reset clears fills and control only; entry storage needs no clearing pass
//  a held result stalls the sequencer only when the next result must go out
module deferred_release_cache_aging (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // cmd, handle_in, key_hash, zero fill
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // status, handle_out, zero fill
  output logic         m_axis_tuser,  // kind_out
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i
);
  import drca_pkg::*;

  logic [1:0] keep_q;
  mem_req_t   mem_req;
  entry_t     mem_rdata;
  res_t       out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepReset;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  drca_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  drca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tdata[1:0]),
    .in_kind_i   (s_axis_tuser),
    .in_handle_i (s_axis_tdata[33:2]),
    .in_hash_i   (s_axis_tdata[97:34]),
    .keep_i      (keep_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  assign m_axis_tdata = {6'b0, out_res.handle, out_res.status};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
